FILE: rtl/core/tdo_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tunnel diode oscillator step package
// Shared types and fixed-point constants for the oscillator step unit.
// ---------------------------------------------------------------------------
package tdo_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_RATIO_HI,
      ST_RATIO_SUM,
      ST_EXP_LO,
      ST_EXP_HI,
      ST_EXP_SUM,
      ST_EXP_ARG,
      ST_EXP_SPLIT,
      ST_EXP_FRAC,
      ST_HORNER_MUL,
      ST_HORNER_STEP,
      ST_HORNER_DIV,
      ST_EXP_SCALE,
      ST_THERMAL_ADJ,
      ST_TERM_ADD,
      ST_KNEE_ACC,
      ST_ROUND,
      ST_DI_MUL,
      ST_DI_SCALE,
      ST_DV_DIFF,
      ST_DV_HI,
      ST_DV_LO,
      ST_DV_SUM,
      ST_DV_CLAMP,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      TERM_KNEE,
      TERM_TUNNEL,
      TERM_THERMAL
   } term_type;

   localparam logic CSR_CURRENT_GAIN = 1'b0;
   localparam logic CSR_VOLTAGE_GAIN = 1'b1;

   localparam logic [31:0] ONE_Q30  = 32'd1073741824;
   localparam logic [31:0] LN2_Q30  = 32'd744261118;
   localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP_5  = 32'hCCCC_CCCD;

   localparam logic [35:0] RATIO_C  = 36'd16519104985;
   localparam logic [35:0] T1_C     = 36'd23832030841;
   localparam logic [35:0] T2_C     = 36'd15490820046;
   localparam logic [35:0] T3_C     = 36'd59580077103;

   localparam logic signed [39:0] T1_B  = 40'sd1549082005;
   localparam logic signed [39:0] T2_B  = -40'sd7914938324;
   localparam logic signed [39:0] T3_B  = -40'sd21401358790;
   localparam logic signed [39:0] T_MIN = -40'sd51539607552;
   localparam logic signed [39:0] T_MAX = 40'sd42949672960;

   localparam logic [63:0] EXP_SAT  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] ISAT_Q32 = 64'd4295;
   localparam logic [48:0] ID_MAX   = 49'd2147483647;

   localparam logic [39:0] DV_MAX   = 40'd3277;
   localparam logic signed [17:0] V_MIN = -18'sd6554;
   localparam logic signed [17:0] V_MAX = 18'sd52429;
   localparam logic signed [32:0] I_MAX = 33'sd2147483647;
   localparam logic signed [32:0] I_MIN = -33'sd2147483648;

endpackage

FILE: rtl/core/tdo_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
module tdo_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

FILE: rtl/core/tunnel_diode_oscillator_step_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tunnel diode oscillator step unit
// One forward-Euler step of a biased tunnel diode oscillator per item.
// ---------------------------------------------------------------------------
// Usage:
// Each request item carries a bias voltage (signed Q2.16 V). The unit works
// out the diode current at the stored capacitor voltage, then updates the
// capacitor voltage and inductor current and returns all three in one
// response item. The user must write the gains through the csr port only
// while idle; the unit itself does not enforce this. A negative capacitor
// voltage skips the exponential series and goes straight to the Euler
// update. The states are sequenced around the single shared 32x32
// multiplier, which serves the ratio, three exponentials (each a six-step
// Horner series with reciprocal divides) and the Euler update.
// Only one item is in flight; req_stall is high until the result has been
// moved into the response register. A stalled response holds its value, and
// the unit will not finish the next item until the previous one is taken.
// Reset clears the state to zero volts and zero milliamps and both gains.
// ---------------------------------------------------------------------------
module tunnel_diode_oscillator_step_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [17:0] req_bias_voltage,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_cap_voltage,
   output logic signed [31:0] rsp_inductor_current,
   output logic signed [31:0] rsp_diode_current,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [31:0]        csr_data
);
   import tdo_pkg::*;

   state_type state_ff, state_in;
   term_type  term_ff, term_in;
   logic [2:0]  deg_ff, deg_in;
   logic [31:0] cgain_ff, vgain_ff;
   logic signed [17:0] bias_ff, bias_in;
   logic signed [16:0] cap_ff, cap_in;
   logic signed [31:0] ind_ff, ind_in;
   logic [63:0] acc_ff, acc_in;
   logic [23:0] r_ff, r_in;
   logic signed [39:0] t_ff, t_in;
   logic signed [7:0] sh_ff, sh_in;
   logic [29:0] u_ff, u_in;
   logic [31:0] s_ff, s_in;
   logic [63:0] e_ff, e_in;
   logic [63:0] sum_ff, sum_in;
   logic signed [31:0] id_ff, id_in;
   logic neg_ff, neg_in;
   logic signed [27:0] di_ff, di_in;
   logic [32:0] mag_ff, mag_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] p_ff, p_in;
   logic ovf_ff, ovf_in;
   logic signed [12:0] dv_ff, dv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] rsp_cap_ff, rsp_cap_in;
   logic signed [31:0] rsp_ind_ff, rsp_ind_in;
   logic signed [31:0] rsp_id_ff, rsp_id_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        req_take, out_free;

   logic [15:0] uv;
   logic [35:0] c_sel;
   logic signed [39:0] b_sel;
   logic [63:0] full;
   logic signed [39:0] x_arg;
   logic t_lo, t_hi;
   logic [29:0] f_val;
   logic signed [9:0] k_val;
   logic [31:0] x_h;
   logic [63:0] e_scaled;
   logic [5:0]  neg_sh;
   logic [64:0] rnd;
   logic [48:0] q_val;
   logic signed [18:0] d1;
   logic [18:0] mag1;
   logic [63:0] dr;
   logic [26:0] dmag;
   logic signed [32:0] d2;
   logic [63:0] pr;
   logic [12:0] dvm;
   logic signed [17:0] nv;
   logic signed [32:0] ni;
   logic signed [31:0] vx;

   tdo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Fixed datapath pieces shared by several states.
   always_comb begin
      uv = cap_ff[15:0];
      case (term_ff)
         TERM_KNEE:   begin c_sel = T1_C; b_sel = T1_B; end
         TERM_TUNNEL: begin c_sel = T2_C; b_sel = T2_B; end
         default:     begin c_sel = T3_C; b_sel = T3_B; end
      endcase
      full  = acc_ff + {prod[31:0], 32'd0};
      x_arg = $signed({4'd0, acc_ff[51:16]});
      t_lo  = (t_ff < T_MIN);
      t_hi  = (t_ff > T_MAX);
      f_val = (t_lo || t_hi) ? 30'd0 : t_ff[29:0];
      k_val = t_lo ? -10'sd48 : (t_hi ? 10'sd40 : $signed(t_ff[39:30]));
      x_h   = prod[61:30];
      neg_sh = 6'(-sh_ff);
      if (sh_ff > 8'sd30) begin
         e_scaled = EXP_SAT;
      end else if (!sh_ff[7]) begin
         e_scaled = {32'd0, s_ff} << sh_ff[4:0];
      end else begin
         e_scaled = {32'd0, s_ff} >> neg_sh;
      end
      rnd   = {1'b0, sum_ff} + 65'd32768;
      q_val = rnd[64:16];
      d1    = {bias_ff[17], bias_ff} - {{2{cap_ff[16]}}, cap_ff};
      mag1  = d1[18] ? 19'(-d1) : 19'(d1);
      dr    = prod + 64'd8388608;
      dmag  = dr[50:24];
      d2    = {ind_ff[31], ind_ff} - {id_ff[31], id_ff};
      pr    = (p_ff + 64'd8388608) >> 24;
      dvm   = (ovf_ff || (pr[39:0] > DV_MAX) || (|pr[63:40])) ? 13'(DV_MAX) : pr[12:0];
      nv    = {cap_ff[16], cap_ff} + {{5{dv_ff[12]}}, dv_ff};
      ni    = {ind_ff[31], ind_ff} + {{5{di_ff[27]}}, di_ff};
      vx    = {{15{cap_ff[16]}}, cap_ff};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (req_take) state_in = ST_START;
         ST_START:       state_in = cap_ff[16] ? ST_DI_MUL : ST_RATIO_HI;
         ST_RATIO_HI:    state_in = ST_RATIO_SUM;
         ST_RATIO_SUM:   state_in = ST_EXP_LO;
         ST_EXP_LO:      state_in = ST_EXP_HI;
         ST_EXP_HI:      state_in = ST_EXP_SUM;
         ST_EXP_SUM:     state_in = ST_EXP_ARG;
         ST_EXP_ARG:     state_in = ST_EXP_SPLIT;
         ST_EXP_SPLIT:   state_in = ST_EXP_FRAC;
         ST_EXP_FRAC:    state_in = ST_HORNER_MUL;
         ST_HORNER_MUL:  state_in = ST_HORNER_STEP;
         ST_HORNER_STEP: begin
            case (deg_ff)
               3'd6, 3'd5, 3'd3: state_in = ST_HORNER_DIV;
               3'd1:             state_in = ST_EXP_SCALE;
               default:          state_in = ST_HORNER_MUL;
            endcase
         end
         ST_HORNER_DIV:  state_in = ST_HORNER_MUL;
         ST_EXP_SCALE:   state_in = (term_ff == TERM_THERMAL) ? ST_THERMAL_ADJ : ST_TERM_ADD;
         ST_THERMAL_ADJ: state_in = ST_TERM_ADD;
         ST_TERM_ADD: begin
            case (term_ff)
               TERM_KNEE:   state_in = ST_KNEE_ACC;
               TERM_TUNNEL: state_in = ST_EXP_LO;
               default:     state_in = ST_ROUND;
            endcase
         end
         ST_KNEE_ACC:    state_in = ST_EXP_LO;
         ST_ROUND:       state_in = ST_DI_MUL;
         ST_DI_MUL:      state_in = ST_DI_SCALE;
         ST_DI_SCALE:    state_in = ST_DV_DIFF;
         ST_DV_DIFF:     state_in = ST_DV_HI;
         ST_DV_HI:       state_in = ST_DV_LO;
         ST_DV_LO:       state_in = ST_DV_SUM;
         ST_DV_SUM:      state_in = ST_DV_CLAMP;
         ST_DV_CLAMP:    state_in = ST_WRITE;
         ST_WRITE:       if (out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      term_in = term_ff;
      deg_in = deg_ff;
      bias_in = bias_ff;
      cap_in = cap_ff;
      ind_in = ind_ff;
      acc_in = acc_ff;
      r_in = r_ff;
      t_in = t_ff;
      sh_in = sh_ff;
      u_in = u_ff;
      s_in = s_ff;
      e_in = e_ff;
      sum_in = sum_ff;
      id_in = id_ff;
      neg_in = neg_ff;
      di_in = di_ff;
      mag_in = mag_ff;
      hi_in = hi_ff;
      p_in = p_ff;
      ovf_in = ovf_ff;
      dv_in = dv_ff;
      rsp_cap_in = rsp_cap_ff;
      rsp_ind_in = rsp_ind_ff;
      rsp_id_in = rsp_id_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: if (req_take) bias_in = req_bias_voltage;
         ST_START: begin
            if (cap_ff[16]) begin
               id_in = (vx <<< 5) + (vx <<< 4) + (vx <<< 1);
            end else begin
               mul_a = {16'd0, uv};
               mul_b = RATIO_C[31:0];
            end
         end
         ST_RATIO_HI: begin
            acc_in = prod;
            mul_a = {16'd0, uv};
            mul_b = {28'd0, RATIO_C[35:32]};
         end
         ST_RATIO_SUM: begin
            r_in = full[49:26];
            term_in = TERM_KNEE;
         end
         ST_EXP_LO: begin
            mul_a = {16'd0, uv};
            mul_b = c_sel[31:0];
         end
         ST_EXP_HI: begin
            acc_in = prod;
            mul_a = {16'd0, uv};
            mul_b = {28'd0, c_sel[35:32]};
         end
         ST_EXP_SUM: acc_in = full;
         ST_EXP_ARG: t_in = (term_ff == TERM_KNEE) ? b_sel - x_arg : x_arg + b_sel;
         ST_EXP_SPLIT: begin
            sh_in = 8'(k_val) + 8'sd2;
            mul_a = {2'd0, f_val};
            mul_b = LN2_Q30;
         end
         ST_EXP_FRAC: begin
            u_in = prod[59:30];
            s_in = ONE_Q30;
            deg_in = 3'd6;
         end
         ST_HORNER_MUL: begin
            mul_a = {2'd0, u_ff};
            mul_b = s_ff;
         end
         ST_HORNER_STEP: begin
            // Divides by six, five and three go through a reciprocal product.
            case (deg_ff)
               3'd6, 3'd3: begin mul_a = x_h; mul_b = RECIP_3; end
               3'd5:       begin mul_a = x_h; mul_b = RECIP_5; end
               3'd4:       begin s_in = ONE_Q30 + (x_h >> 2); deg_in = deg_ff - 3'd1; end
               3'd2:       begin s_in = ONE_Q30 + (x_h >> 1); deg_in = deg_ff - 3'd1; end
               default:    s_in = ONE_Q30 + x_h;
            endcase
         end
         ST_HORNER_DIV: begin
            if (deg_ff == 3'd3) s_in = ONE_Q30 + {1'b0, prod[63:33]};
            else                s_in = ONE_Q30 + {2'd0, prod[63:34]};
            deg_in = deg_ff - 3'd1;
         end
         ST_EXP_SCALE: e_in = e_scaled;
         ST_THERMAL_ADJ: e_in = (e_ff > ISAT_Q32) ? e_ff - ISAT_Q32 : 64'd0;
         ST_TERM_ADD: begin
            case (term_ff)
               TERM_KNEE: begin
                  mul_a = {8'd0, r_ff};
                  mul_b = e_ff[35:4];
               end
               TERM_TUNNEL: begin
                  sum_in = sum_ff + e_ff;
                  term_in = TERM_THERMAL;
               end
               default: sum_in = sum_ff + e_ff;
            endcase
         end
         ST_KNEE_ACC: begin
            sum_in = {16'd0, prod[63:16]};
            term_in = TERM_TUNNEL;
         end
         ST_ROUND: id_in = (q_val > ID_MAX) ? 32'sh7FFF_FFFF : $signed(q_val[31:0]);
         ST_DI_MUL: begin
            neg_in = d1[18];
            mul_a = {13'd0, mag1};
            mul_b = cgain_ff;
         end
         ST_DI_SCALE: di_in = neg_ff ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
         ST_DV_DIFF: begin
            neg_in = d2[32];
            mag_in = d2[32] ? 33'(-d2) : 33'(d2);
         end
         ST_DV_HI: begin
            mul_a = {15'd0, mag_ff[32:16]};
            mul_b = vgain_ff;
         end
         ST_DV_LO: begin
            hi_in = prod;
            mul_a = {16'd0, mag_ff[15:0]};
            mul_b = vgain_ff;
         end
         ST_DV_SUM: begin
            ovf_in = |hi_ff[63:46];
            p_in = (hi_ff << 16) + prod;
         end
         ST_DV_CLAMP: dv_in = neg_ff ? -$signed(dvm) : $signed(dvm);
         ST_WRITE: begin
            if (out_free) begin
               if (nv > V_MAX)      cap_in = 17'(V_MAX);
               else if (nv < V_MIN) cap_in = 17'(V_MIN);
               else                 cap_in = nv[16:0];
               if (ni > I_MAX)      ind_in = 32'(I_MAX);
               else if (ni < I_MIN) ind_in = 32'(I_MIN);
               else                 ind_in = ni[31:0];
               rsp_cap_in = cap_in;
               rsp_ind_in = ind_in;
               rsp_id_in = id_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff <= '0;
         ind_ff <= '0;
         cgain_ff <= '0;
         vgain_ff <= '0;
         term_ff <= TERM_KNEE;
         deg_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff <= cap_in;
         ind_ff <= ind_in;
         term_ff <= term_in;
         deg_ff <= deg_in;
         if (csr_write && csr_index == CSR_CURRENT_GAIN) cgain_ff <= csr_data;
         if (csr_write && csr_index == CSR_VOLTAGE_GAIN) vgain_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      bias_ff <= bias_in;
      acc_ff <= acc_in;
      r_ff <= r_in;
      t_ff <= t_in;
      sh_ff <= sh_in;
      u_ff <= u_in;
      s_ff <= s_in;
      e_ff <= e_in;
      sum_ff <= sum_in;
      id_ff <= id_in;
      neg_ff <= neg_in;
      di_ff <= di_in;
      mag_ff <= mag_in;
      hi_ff <= hi_in;
      p_ff <= p_in;
      ovf_ff <= ovf_in;
      dv_ff <= dv_in;
      rsp_cap_ff <= rsp_cap_in;
      rsp_ind_ff <= rsp_ind_in;
      rsp_id_ff <= rsp_id_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cap_voltage = rsp_cap_ff;
   assign rsp_inductor_current = rsp_ind_ff;
   assign rsp_diode_current = rsp_id_ff;

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("response raised outside the write state");

   a_cap_in_range: assert property (@(posedge clock) disable iff (reset)
      ($signed(cap_ff) >= V_MIN) && ($signed(cap_ff) <= V_MAX))
      else $error("capacitor voltage outside its limits");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_START))
      else $error("accepted item did not start a step");

   a_horner_degree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HORNER_STEP) |-> ((deg_ff >= 3'd1) && (deg_ff <= 3'd6)))
      else $error("series degree out of range");

endmodule

FILE: verif/tunnel_diode_oscillator_step_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tunnel diode oscillator step unit testbench
// Drives bias items through the step unit, mostly under random idling on both sides.
// Every response is compared with a fixed-point model of the Euler step held
// in this bench, across several gain settings including zero and full scale.
// ---------------------------------------------------------------------------
module tunnel_diode_oscillator_step_unit_tb;
   import tdo_pkg::*;

   localparam int                 ITEM_COUNT  = 2000;
   localparam int                 PHASE_ITEMS = 250;
   localparam int                 IDLE_LIMIT  = 4000;
   localparam int                 SETTLE      = 120;
   localparam longint             ONE         = 64'sd1073741824;
   localparam longint unsigned    LN2         = 64'd744261118;
   localparam longint             KNEE_B      = 64'sd1549082005;
   localparam longint             TUNNEL_B    = -64'sd7914938324;
   localparam longint             THERMAL_B   = -64'sd21401358790;
   localparam longint unsigned    KNEE_C      = 64'd23832030841;
   localparam longint unsigned    TUNNEL_C    = 64'd15490820046;
   localparam longint unsigned    THERMAL_C   = 64'd59580077103;
   localparam longint unsigned    RATIO_K     = 64'd16519104985;
   localparam longint unsigned    LEAK_Q32    = 64'd4295;
   localparam longint             STEP_LIMIT  = 64'sd3277;
   localparam longint             CAP_LO      = -64'sd6554;
   localparam longint             CAP_HI      = 64'sd52429;
   localparam longint             AMP_MAX     = 64'sd2147483647;
   localparam longint             AMP_MIN     = -64'sd2147483648;

   typedef struct {
      logic signed [16:0] cap;
      logic signed [31:0] ind;
      logic signed [31:0] dio;
   } step_result_t;

   typedef struct {
      bit                 wr;
      logic [31:0]        gi;
      logic [31:0]        gv;
      logic signed [17:0] bias;
      bit                 typed;
      logic signed [16:0] cap;
      logic signed [31:0] ind;
   } step_row_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [17:0] req_bias_voltage;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [16:0] rsp_cap_voltage;
   logic signed [31:0] rsp_inductor_current;
   logic signed [31:0] rsp_diode_current;
   logic               csr_write;
   logic               csr_index;
   logic [31:0]        csr_data;

   // Model state, updated as items are accepted, and gains, updated as written.
   int                 model_cap;
   int                 model_ind;
   longint unsigned    model_gain_i;
   longint unsigned    model_gain_v;

   step_result_t       pending_steps[$];
   int                 error_count;
   int                 idle_cycles;
   bit                 quiet;

   tunnel_diode_oscillator_step_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_bias_voltage     (req_bias_voltage),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cap_voltage      (rsp_cap_voltage),
      .rsp_inductor_current (rsp_inductor_current),
      .rsp_diode_current    (rsp_diode_current),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // 2^t with t in signed Q30, returned in Q32.
   function automatic longint unsigned exp2_q32(longint t);
      longint unsigned w, f, u, s;
      int              k, sh;
      if (t < -48 * ONE) t = -48 * ONE;
      if (t > 40 * ONE) t = 40 * ONE;
      w = t + 48 * ONE;
      k = int'(w >> 30) - 48;
      f = w & (ONE - 1);
      u = (f * LN2) >> 30;
      s = ONE;
      s = ONE + ((u * s) >> 30) / 6;
      s = ONE + ((u * s) >> 30) / 5;
      s = ONE + ((u * s) >> 30) / 4;
      s = ONE + ((u * s) >> 30) / 3;
      s = ONE + ((u * s) >> 30) / 2;
      s = ONE + ((u * s) >> 30);
      sh = k + 2;
      if (sh > 30) return 64'd1 << 62;
      if (sh >= 0) return s << sh;
      return s >> (-sh);
   endfunction

   function automatic int diode_ma(int v);
      longint unsigned uv, r, e1, e2, e3, knee, leak, sum, q;
      if (v < 0) return v * 50;
      uv   = longint'(v);
      r    = (uv * RATIO_K) >> 16;
      e1   = exp2_q32(KNEE_B - $signed((uv * KNEE_C) >> 16));
      knee = ((r >> 10) * (e1 >> 4)) >> 16;
      e2   = exp2_q32($signed((uv * TUNNEL_C) >> 16) + TUNNEL_B);
      e3   = exp2_q32($signed((uv * THERMAL_C) >> 16) + THERMAL_B);
      leak = (e3 > LEAK_Q32) ? e3 - LEAK_Q32 : 64'd0;
      sum  = knee + e2 + leak;
      q    = (sum + 64'd32768) >> 16;
      if (q > 64'd2147483647) q = 64'd2147483647;
      return int'(q);
   endfunction

   // Advances the model by one Euler step and returns the expected response.
   function automatic step_result_t euler_step(logic signed [17:0] bias);
      step_result_t    res;
      longint          b, v, i, id, d, di, dv, nv, ni;
      longint unsigned mag, p, hi, lo;
      bit              neg;
      b  = longint'(bias);
      v  = longint'(model_cap);
      i  = longint'(model_ind);
      id = longint'(diode_ma(model_cap));

      d   = b - v;
      neg = d < 0;
      mag = neg ? -d : d;
      p   = mag * model_gain_i;
      di  = $signed((p + (64'd1 << 23)) >> 24);
      if (neg) di = -di;

      d   = i - id;
      neg = d < 0;
      mag = neg ? -d : d;
      hi  = (mag >> 16) * model_gain_v;
      lo  = (mag & 64'hFFFF) * model_gain_v;
      if (hi >= (64'd1 << 46)) begin
         dv = STEP_LIMIT;
      end else begin
         p  = ((hi << 16) + lo + (64'd1 << 23)) >> 24;
         dv = (p > STEP_LIMIT) ? STEP_LIMIT : $signed(p);
      end
      if (neg) dv = -dv;

      nv = v + dv;
      if (nv > CAP_HI) nv = CAP_HI;
      if (nv < CAP_LO) nv = CAP_LO;
      ni = i + di;
      if (ni > AMP_MAX) ni = AMP_MAX;
      if (ni < AMP_MIN) ni = AMP_MIN;
      model_cap = int'(nv);
      model_ind = int'(ni);
      res.cap = nv[16:0];
      res.ind = ni[31:0];
      res.dio = id[31:0];
      return res;
   endfunction

   // Gains change only once the unit has drained and settled.
   task automatic write_gains(logic [31:0] gi, logic [31:0] gv);
      while (pending_steps.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write = 1'b1;
      csr_index = CSR_CURRENT_GAIN;
      csr_data  = gi;
      @(negedge clock);
      csr_index = CSR_VOLTAGE_GAIN;
      csr_data  = gv;
      @(negedge clock);
      csr_write = 1'b0;
      model_gain_i = 64'(gi);
      model_gain_v = 64'(gv);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_bias(logic signed [17:0] bias, bit typed,
                            logic signed [16:0] cap, logic signed [31:0] ind);
      step_result_t exp_res;
      int           gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_bias_voltage = bias;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      exp_res = euler_step(bias);
      if (typed && (exp_res.cap !== cap || exp_res.ind !== ind)) begin
         $error("cap_voltage/inductor_current: expected %0d/%0d, model gives %0d/%0d",
                cap, ind, exp_res.cap, exp_res.ind);
         error_count++;
      end
      pending_steps.push_back(exp_res);
      @(negedge clock);
   endtask

   function automatic logic signed [17:0] draw_bias();
      case ($urandom_range(0, 9))
         0:       return 18'($urandom());
         1:       return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
         default: return 18'($urandom_range(6000, 34000));
      endcase
   endfunction

   function automatic logic [31:0] draw_gain(int kind, bit for_voltage);
      case (kind)
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         default: return for_voltage ? $urandom_range(1 << 16, 1 << 23)
                                     : $urandom_range(1 << 20, 1 << 26);
      endcase
   endfunction

   step_row_t directed[] = '{
      '{1'b0, 32'd0, 32'd0, 18'sd0,       1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd65536,   1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, -18'sd65536,  1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd131071,  1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, -18'sd131072, 1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sh15555,   1'b1, 17'sd0,     32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sh2AAAA,   1'b1, 17'sd0,     32'sd0},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'sd65536, 1'b1, -17'sd3277, 32'sd16777216},
      '{1'b0, 32'd0, 32'd0, -18'sd131072, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, -18'sd131072, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, -18'sd131072, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd131071,  1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd131071,  1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd131071,  1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd131071,  1'b0, 17'sd0, 32'sd0},
      '{1'b1, 32'd16777216, 32'd1677722, 18'sd19661, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd22938, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd26214, 1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd0,     1'b0, 17'sd0, 32'sd0},
      '{1'b0, 32'd0, 32'd0, 18'sd32768, 1'b0, 17'sd0, 32'sd0}
   };

   // Response side: a random hold-off before each item is taken.
   initial begin
      int hold;
      rsp_stall = 1'b1;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 14);
         rsp_stall = (hold > 0);
         repeat (hold) @(negedge clock);
         rsp_stall = 1'b0;
         forever begin
            @(posedge clock);
            if (rsp_valid) break;
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      step_result_t exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            $error("unexpected response item: cap_voltage %0d", rsp_cap_voltage);
            error_count++;
         end else begin
            exp_res = pending_steps.pop_front();
            if (rsp_cap_voltage !== exp_res.cap) begin
               $error("cap_voltage: expected %0d, got %0d", exp_res.cap, rsp_cap_voltage);
               error_count++;
            end
            if (rsp_inductor_current !== exp_res.ind) begin
               $error("inductor_current: expected %0d, got %0d",
                      exp_res.ind, rsp_inductor_current);
               error_count++;
            end
            if (rsp_diode_current !== exp_res.dio) begin
               $error("diode_current: expected %0d, got %0d",
                      exp_res.dio, rsp_diode_current);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int kind_i, kind_v;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_bias_voltage = '0;
      csr_write        = 1'b0;
      csr_index        = CSR_CURRENT_GAIN;
      csr_data         = '0;
      error_count      = 0;
      idle_cycles      = 0;
      quiet            = 1'b0;
      model_cap        = 0;
      model_ind        = 0;
      model_gain_i     = 0;
      model_gain_v     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[n]) begin
         if (directed[n].wr) begin
            req_valid = 1'b0;
            write_gains(directed[n].gi, directed[n].gv);
         end
         send_bias(directed[n].bias, directed[n].typed, directed[n].cap, directed[n].ind);
      end

      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            req_valid = 1'b0;
            // Realistic gains in half the draws, so the voltage sweeps the diode curve.
            kind_i = (n == 0) ? 1 : $urandom_range(0, 5);
            kind_v = (n == 0) ? 0 : $urandom_range(0, 5);
            write_gains(draw_gain(kind_i, 1'b0), draw_gain(kind_v, 1'b1));
            quiet = ((n / PHASE_ITEMS) % 3 == 2);
         end
         send_bias(draw_bias(), 1'b0, '0, '0);
      end
      req_valid = 1'b0;
      quiet     = 1'b0;

      while (pending_steps.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
